FILE: hdl/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg: shared types and constants for the touch centroid pipeline
// Sample widths, the divider depth, pipeline latencies and the result record
// that each axis lane hands to the merge stage.
// ----------------------------------------------------------------------------
package tcp_pkg;

    // Width of one baseline-corrected reading.
    localparam int SAMPLE_WIDTH = 24;
    localparam int CHANNELS     = 4;

    // Axis sum and twice the weighted sum (weights -3, -1, 1, 3).
    localparam int SUM_W = SAMPLE_WIDTH + 2;
    localparam int TW_W  = SAMPLE_WIDTH + 4;

    // Position format: Q2.14, the weighted sum is doubled, so scale by 2^13.
    localparam int Q_FRAC = 13;
    localparam int Q_BITS = 16;
    localparam int NUM_W  = TW_W - 1 + Q_FRAC;
    localparam int REM_W  = SUM_W + Q_BITS;
    localparam int POS_W  = 16;
    localparam logic signed [POS_W-1:0] POS_MAX = 16'sd32767;

    // Pressure: total * 256 / 2000 is total * 16 / 125.
    localparam int PRESS_W     = 25;
    localparam int TOT_W       = SAMPLE_WIDTH + 3;
    localparam int PM_W        = TOT_W + 4;
    localparam int PRESS_K     = PM_W;
    localparam int PRESS_R_W   = PRESS_K - 6;
    localparam int PRESS_Q_W   = PM_W - 6;
    localparam logic [PRESS_R_W-1:0] PRESS_RECIP = PRESS_R_W'((64'd1 << PRESS_K) / 125);
    localparam logic [6:0] PRESS_DIV = 7'd125;

    // Latencies: lane output after 3 setup stages and one stage per quotient bit.
    localparam int LANE_DEPTH  = 3 + Q_BITS;
    localparam int PRESS_DEPTH = 6;
    localparam int PRESS_DLY   = LANE_DEPTH - PRESS_DEPTH;
    localparam int PIPE_DEPTH  = LANE_DEPTH + 1;

    // Stream widths.
    localparam int S_TDATA_W = ((2 * CHANNELS * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * POS_W + PRESS_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // Result of one axis lane, before saturation and sign.
    typedef struct packed {
        logic [Q_BITS-1:0] mag;
        logic              neg;
        logic              zero;
        logic              ovf;
    } lane_res_t;

endpackage

FILE: hdl/touch_centroid_position.sv
// ----------------------------------------------------------------------------
// touch_centroid_position: weighted centroid of one touch-pad scan
// Takes eight readings per word and returns the column and row centroids in
// Q2.14 with their flags, and the scaled pressure.
// ----------------------------------------------------------------------------
// The block accepts one scan word per clock while the output is not stalled
// and returns one result word per scan, in order. The latency is set by the
// 16-stage restoring divider in each of the two axis lanes, one stage per
// quotient bit, plus three setup stages and the output register. While
// the output is stalled the whole pipeline holds; a one-word skid buffer at
// the input keeps s_tready a registered signal. Column and row lanes run side
// by side and a merge stage saturates, signs and packs the two positions
// with the pressure, which is computed alongside by a reciprocal multiply.
// ----------------------------------------------------------------------------
module touch_centroid_position
    import tcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: col0, col1, col2, col3, row0, row1, row2, row3 (24 bits each)
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata: x_pos[15:0], y_pos[31:16], pressure[56:32], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: x_bad[0], y_bad[1]
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    logic                   ce;
    logic                   s_tready_reg;
    logic                   s_tready_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [S_TDATA_W-1:0]   skid_data_reg;
    logic [PIPE_DEPTH-1:0]  vld_reg;
    logic [PIPE_DEPTH-1:0]  vld_next;
    logic                   in_valid;
    logic [S_TDATA_W-1:0]   in_data;
    sample_t                cols [CHANNELS];
    sample_t                rows [CHANNELS];
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [PRESS_W-1:0] pressure;
    lane_res_t              x_res;
    lane_res_t              y_res;

    // The pipeline advances unless a finished word waits at the output.
    assign ce = !vld_reg[PIPE_DEPTH-1] || m_tready;

    // Input selection: a word held in the skid buffer goes first.
    assign in_valid = skid_valid_reg || (s_tvalid && s_tready_reg);
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            cols[i] = in_data[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            rows[i] = in_data[(CHANNELS+i)*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        end
    end

    // Skid and valid-line control.
    always_comb begin
        skid_valid_next = skid_valid_reg;
        vld_next        = vld_reg;
        if (ce) begin
            skid_valid_next = 1'b0;
            vld_next        = {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end else if (s_tvalid && s_tready_reg) begin
            skid_valid_next = 1'b1;
        end
        s_tready_next = !skid_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            s_tready_reg   <= 1'b1;
            vld_reg        <= '0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            s_tready_reg   <= s_tready_next;
            vld_reg        <= vld_next;
        end
    end

    // Skid buffer payload.
    always_ff @(posedge aclk) begin
        if (!ce && s_tvalid && s_tready_reg) begin
            skid_data_reg <= s_tdata;
        end
    end

    // Column and row lanes.
    tcp_axis_lane u_lane_x (
        .aclk  (aclk),
        .ce    (ce),
        .smp   (cols),
        .sum_o (sum_x),
        .res   (x_res)
    );

    tcp_axis_lane u_lane_y (
        .aclk  (aclk),
        .ce    (ce),
        .smp   (rows),
        .sum_o (sum_y),
        .res   (y_res)
    );

    // Pressure from both axis sums.
    tcp_pressure u_pressure (
        .aclk     (aclk),
        .ce       (ce),
        .sum_x    (sum_x),
        .sum_y    (sum_y),
        .pressure (pressure)
    );

    // Merge and output register.
    tcp_merge u_merge (
        .aclk     (aclk),
        .ce       (ce),
        .x_res    (x_res),
        .y_res    (y_res),
        .pressure (pressure),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign s_tready = s_tready_reg;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

endmodule

FILE: hdl/tcp_axis_lane.sv
// ----------------------------------------------------------------------------
// tcp_axis_lane: weighted sum and pipelined ratio for one axis
// Forms the axis sum and twice the weighted sum, then divides the scaled
// weighted sum by the axis sum with one restoring step per stage.
// ----------------------------------------------------------------------------
module tcp_axis_lane
    import tcp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   ce,
    input  sample_t                smp [CHANNELS],
    output logic signed [SUM_W-1:0] sum_o,
    output lane_res_t              res
);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [TW_W-1:0]  tw_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [SUM_W-1:0]        den_reg;
    logic                    neg_reg;
    logic                    zero_reg;

    logic [REM_W-1:0]  rem_reg  [Q_BITS+1];
    logic [SUM_W-1:0]  dsum_reg [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg    [Q_BITS+1];
    logic              neg_d    [Q_BITS+1];
    logic              zero_d   [Q_BITS+1];
    logic              ovf_d    [Q_BITS+1];

    // Stage 1: axis sum and twice the weighted sum, both exact.
    always_ff @(posedge aclk) begin
        if (ce) begin
            sum_reg <= SUM_W'(smp[0]) + SUM_W'(smp[1]) + SUM_W'(smp[2]) + SUM_W'(smp[3]);
            tw_reg  <= TW_W'(smp[3]) * TW_W'(3) - TW_W'(smp[0]) * TW_W'(3) - TW_W'(smp[1])
                       + TW_W'(smp[2]);
        end
    end

    // Stage 2: magnitudes, quotient sign and the zero-sum case.
    always_ff @(posedge aclk) begin
        if (ce) begin
            num_reg  <= {(tw_reg[TW_W-1] ? (TW_W-1)'(-tw_reg) : (TW_W-1)'(tw_reg)),
                         {Q_FRAC{1'b0}}};
            den_reg  <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            neg_reg  <= tw_reg[TW_W-1] ^ sum_reg[SUM_W-1];
            zero_reg <= (sum_reg == '0);
        end
    end

    // Stage 3: a quotient of 2^16 or more cannot fit and saturates.
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= REM_W'(num_reg);
            dsum_reg[0] <= den_reg;
            q_reg[0]    <= '0;
            neg_d[0]    <= neg_reg;
            zero_d[0]   <= zero_reg;
            ovf_d[0]    <= (REM_W'(num_reg) >= {den_reg, {Q_BITS{1'b0}}});
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < Q_BITS; k++) begin : g_div
        localparam int SH = Q_BITS - 1 - k;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign trial = REM_W'(dsum_reg[k]) << SH;
        assign ge    = (rem_reg[k] >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k+1]  <= ge ? (rem_reg[k] - trial) : rem_reg[k];
                dsum_reg[k+1] <= dsum_reg[k];
                q_reg[k+1]    <= {q_reg[k][Q_BITS-2:0], ge};
                neg_d[k+1]    <= neg_d[k];
                zero_d[k+1]   <= zero_d[k];
                ovf_d[k+1]    <= ovf_d[k];
            end
        end
    end

    assign sum_o    = sum_reg;
    assign res.mag  = q_reg[Q_BITS];
    assign res.neg  = neg_d[Q_BITS];
    assign res.zero = zero_d[Q_BITS];
    assign res.ovf  = ovf_d[Q_BITS];

endmodule

FILE: hdl/tcp_pressure.sv
// ----------------------------------------------------------------------------
// tcp_pressure: total pressure from the two axis sums
// Computes (total * 256) / 2000 truncated toward zero with a reciprocal
// multiply and one correction step, then delays it to line up with the lanes.
// ----------------------------------------------------------------------------
module tcp_pressure
    import tcp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      ce,
    input  logic signed [SUM_W-1:0]   sum_x,
    input  logic signed [SUM_W-1:0]   sum_y,
    output logic signed [PRESS_W-1:0] pressure
);

    logic signed [TOT_W-1:0]         tot_reg;
    logic [PM_W-1:0]                 m_reg;
    logic                            neg_reg;
    logic [PM_W-1:0]                 m2_reg;
    logic                            neg2_reg;
    logic [PM_W+PRESS_R_W-1:0]       prod_reg;
    logic [PRESS_Q_W-1:0]            mag_reg;
    logic                            neg3_reg;
    logic signed [PRESS_W-1:0]       dly_reg [PRESS_DLY+1];

    logic [PRESS_Q_W-1:0] q0;
    logic [PM_W-1:0]      rem;

    // Total of all eight readings.
    always_ff @(posedge aclk) begin
        if (ce) begin
            tot_reg <= TOT_W'(sum_x) + TOT_W'(sum_y);
        end
    end

    // Magnitude times 16, sign kept aside.
    always_ff @(posedge aclk) begin
        if (ce) begin
            m_reg   <= {(tot_reg[TOT_W-1] ? (TOT_W)'(-tot_reg) : (TOT_W)'(tot_reg)), 4'b0000};
            neg_reg <= tot_reg[TOT_W-1];
        end
    end

    // Reciprocal multiply: the estimate is the true quotient or one below it.
    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= (PM_W + PRESS_R_W)'(m_reg) * (PM_W + PRESS_R_W)'(PRESS_RECIP);
            m2_reg   <= m_reg;
            neg2_reg <= neg_reg;
        end
    end

    // Correction: the remainder is below twice the divisor.
    assign q0  = prod_reg[PRESS_K +: PRESS_Q_W];
    assign rem = m2_reg - PM_W'(q0) * PM_W'(PRESS_DIV);

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag_reg  <= (rem >= PM_W'(PRESS_DIV)) ? q0 + 1'b1 : q0;
            neg3_reg <= neg2_reg;
        end
    end

    // Apply the sign, then delay to the lane latency.
    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_reg[0] <= neg3_reg ? -PRESS_W'(mag_reg) : PRESS_W'(mag_reg);
            for (int i = 1; i <= PRESS_DLY; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign pressure = dly_reg[PRESS_DLY];

endmodule

FILE: hdl/tcp_merge.sv
// ----------------------------------------------------------------------------
// tcp_merge: combine lane results into the output word
// Saturates and signs each axis position, sets the flags and registers the
// packed result word.
// ----------------------------------------------------------------------------
module tcp_merge
    import tcp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      ce,
    input  lane_res_t                 x_res,
    input  lane_res_t                 y_res,
    input  logic signed [PRESS_W-1:0] pressure,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser
);

    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic                    x_bad;
    logic                    y_bad;
    logic [M_TDATA_W-1:0]    tdata_reg;
    logic [M_TUSER_W-1:0]    tuser_reg;

    // Position of one axis: zero sum, saturation, or the signed quotient.
    function automatic logic [POS_W:0] axis_out(input lane_res_t r);
        logic signed [POS_W-1:0] pos;
        logic                    bad;
        if (r.zero) begin
            pos = '0;
            bad = 1'b1;
        end else if (r.ovf || r.mag[Q_BITS-1]) begin
            pos = r.neg ? -POS_MAX : POS_MAX;
            bad = 1'b1;
        end else begin
            pos = r.neg ? -POS_W'(r.mag) : POS_W'(r.mag);
            bad = 1'b0;
        end
        return {bad, pos};
    endfunction

    always_comb begin
        {x_bad, x_pos} = axis_out(x_res);
        {y_bad, y_pos} = axis_out(y_res);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (ce) begin
            tdata_reg <= M_TDATA_W'({pressure, y_pos, x_pos});
            tuser_reg <= {y_bad, x_bad};
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

endmodule
